[rtl/irpd_pkg.sv]
// Package for the IR pulse decoder and RGB dimmer: register map, pulse classes,
// key codes, configuration and queue entry types, and the dimming step functions.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package irpd_pkg;

  // Pulse classes as they appear on the result word.
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_START = 2'd1,
    CLS_ONE   = 2'd2,
    CLS_ZERO  = 2'd3
  } cls_t;

  // Register indexes of the configuration port (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_START_MIN  = 3'd0,
    REG_START_MAX  = 3'd1,
    REG_ONE_MIN    = 3'd2,
    REG_ONE_MAX    = 3'd3,
    REG_ZERO_MIN   = 3'd4,
    REG_ZERO_MAX   = 3'd5,
    REG_DUTY_STEP  = 3'd6,
    REG_FULL_SCALE = 3'd7
  } reg_idx_t;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Reset values of the registers.
  localparam logic [TIME_W-1:0]  RST_START_MIN  = 16'd11000;
  localparam logic [TIME_W-1:0]  RST_START_MAX  = 16'd15000;
  localparam logic [TIME_W-1:0]  RST_ONE_MIN    = 16'd1800;
  localparam logic [TIME_W-1:0]  RST_ONE_MAX    = 16'd2800;
  localparam logic [TIME_W-1:0]  RST_ZERO_MIN   = 16'd700;
  localparam logic [TIME_W-1:0]  RST_ZERO_MAX   = 16'd1600;
  localparam logic [LEVEL_W-1:0] RST_DUTY_STEP  = 16'd2000;
  localparam logic [LEVEL_W-1:0] RST_FULL_SCALE = 16'd20000;

  // Compare values after reset: all channels dark.
  localparam logic [LEVEL_W-1:0] RST_LEVEL = 16'd20000;

  // Remote key codes, bit 0 received first.
  localparam logic [CODE_W-1:0] KEY_RED_UP     = 32'hBA45FF00;
  localparam logic [CODE_W-1:0] KEY_RED_DOWN   = 32'hBB44FF00;
  localparam logic [CODE_W-1:0] KEY_GREEN_UP   = 32'hB946FF00;
  localparam logic [CODE_W-1:0] KEY_GREEN_DOWN = 32'hBF40FF00;
  localparam logic [CODE_W-1:0] KEY_BLUE_UP    = 32'hB847FF00;
  localparam logic [CODE_W-1:0] KEY_BLUE_DOWN  = 32'hBC43FF00;
  localparam logic [CODE_W-1:0] KEY_RED_ON     = 32'hF807FF00;
  localparam logic [CODE_W-1:0] KEY_GREEN_ON   = 32'hEA15FF00;
  localparam logic [CODE_W-1:0] KEY_BLUE_ON    = 32'hF609FF00;
  localparam logic [CODE_W-1:0] KEY_ALL_OFF    = 32'hE916FF00;
  localparam logic [CODE_W-1:0] KEY_ALL_ON     = 32'hF20DFF00;

  // Configuration registers as one bundle.
  typedef struct packed {
    logic [TIME_W-1:0]  start_min;
    logic [TIME_W-1:0]  start_max;
    logic [TIME_W-1:0]  one_min;
    logic [TIME_W-1:0]  one_max;
    logic [TIME_W-1:0]  zero_min;
    logic [TIME_W-1:0]  zero_max;
    logic [LEVEL_W-1:0] duty_step;
    logic [LEVEL_W-1:0] full_scale;
  } cfg_t;

  // One classified edge, passed from the front end to the back end.
  typedef struct packed {
    cls_t              cls;
    logic [TIME_W-1:0] interval;
  } pulse_t;

  // Brighter means a smaller compare value; it floors at zero.
  function automatic logic [LEVEL_W-1:0] step_brighter(
    input logic [LEVEL_W-1:0] level,
    input logic [LEVEL_W-1:0] step
  );
    logic [LEVEL_W-1:0] res;
    res = (level >= step) ? (level - step) : '0;
    return res;
  endfunction

  // Darker adds the step and saturates at full scale, also pulling down a
  // level that sits above a lowered full scale.
  function automatic logic [LEVEL_W-1:0] step_darker(
    input logic [LEVEL_W-1:0] level,
    input logic [LEVEL_W-1:0] step,
    input logic [LEVEL_W-1:0] full
  );
    logic [LEVEL_W-1:0] res;
    if ((step <= full) && (level <= (full - step))) begin
      res = level + step;
    end else begin
      res = full;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/irpd_if.sv]
// Channel interfaces of the IR pulse decoder: edge word in, result word out.
// Depends on irpd_pkg for field widths.
`default_nettype none

interface irpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::TIME_W-1:0]   edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

interface irpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    pulse_class;
  logic [irpd_pkg::TIME_W-1:0]   interval;
  logic                          frame_done;
  logic [irpd_pkg::CODE_W-1:0]   frame_code;
  logic [irpd_pkg::LEVEL_W-1:0]  red_compare;
  logic [irpd_pkg::LEVEL_W-1:0]  green_compare;
  logic [irpd_pkg::LEVEL_W-1:0]  blue_compare;

  modport source (output valid, output pulse_class, output interval, output frame_done,
                  output frame_code, output red_compare, output green_compare,
                  output blue_compare, input ready);
  modport sink   (input valid, input pulse_class, input interval, input frame_done,
                  input frame_code, input red_compare, input green_compare,
                  input blue_compare, output ready);
endinterface

`default_nettype wire

[rtl/irpd_front.sv]
// Front end: takes edge timestamps, forms the interval since the previous edge
// and classifies it against the configured windows. Depends on irpd_pkg.
`default_nettype none

module irpd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire irpd_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [irpd_pkg::TIME_W-1:0]  edge_time,
  input  wire logic                         q_full,
  output logic                              q_push,
  output irpd_pkg::pulse_t                  q_data
);

  logic [irpd_pkg::TIME_W-1:0] prev_r, prev_nxt;
  logic [irpd_pkg::TIME_W-1:0] interval;
  logic                        is_start, is_one, is_zero;

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Interval wraps modulo the timer width.
  assign interval = edge_time - prev_r;

  // Strict window compares; start wins over one, one over zero.
  assign is_start = (interval > cfg.start_min) && (interval < cfg.start_max);
  assign is_one   = (interval > cfg.one_min)   && (interval < cfg.one_max);
  assign is_zero  = (interval > cfg.zero_min)  && (interval < cfg.zero_max);

  always_comb begin
    q_data.interval = interval;
    if (is_start) begin
      q_data.cls = irpd_pkg::CLS_START;
    end else if (is_one) begin
      q_data.cls = irpd_pkg::CLS_ONE;
    end else if (is_zero) begin
      q_data.cls = irpd_pkg::CLS_ZERO;
    end else begin
      q_data.cls = irpd_pkg::CLS_NONE;
    end
  end

  // The previous timestamp follows every accepted edge.
  assign prev_nxt = q_push ? edge_time : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/irpd_queue.sv]
// Two-entry queue of classified pulses between the front and back ends.
// Depends on irpd_pkg for the entry type.
`default_nettype none

module irpd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire irpd_pkg::pulse_t  wdata,
  input  wire logic              pop,
  output irpd_pkg::pulse_t       rdata,
  output logic                   full,
  output logic                   empty
);

  irpd_pkg::pulse_t mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/irpd_back.sv]
// Back end: assembles frame bits, applies remote keys to the three compare
// values and holds the result word in an output register. Depends on irpd_pkg.
`default_nettype none

module irpd_back #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire irpd_pkg::cfg_t                 cfg,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  input  wire irpd_pkg::pulse_t               q_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_pulse_class,
  output logic [irpd_pkg::TIME_W-1:0]         out_interval,
  output logic                                out_frame_done,
  output logic [irpd_pkg::CODE_W-1:0]         out_frame_code,
  output logic [irpd_pkg::LEVEL_W-1:0]        out_red,
  output logic [irpd_pkg::LEVEL_W-1:0]        out_green,
  output logic [irpd_pkg::LEVEL_W-1:0]        out_blue
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);

  logic [CNT_W-1:0]                cnt_r, cnt_nxt, cnt_a;
  logic [irpd_pkg::CODE_W-1:0]     code_r, code_nxt, code_a;
  logic [irpd_pkg::LEVEL_W-1:0]    red_r, red_nxt, red_a;
  logic [irpd_pkg::LEVEL_W-1:0]    green_r, green_nxt, green_a;
  logic [irpd_pkg::LEVEL_W-1:0]    blue_r, blue_nxt, blue_a;
  logic                            done;
  logic                            vld_r, vld_nxt;
  logic [1:0]                      cls_r;
  logic [irpd_pkg::TIME_W-1:0]     ivl_r;
  logic                            done_r;

  // Take the next pulse when the output register is free or being drained.
  assign q_pop   = !q_empty && (!vld_r || out_ready);
  assign vld_nxt = q_pop || (vld_r && !out_ready);

  // Bit assembly for the pulse at the queue head.
  always_comb begin
    cnt_a  = cnt_r;
    code_a = code_r;
    case (q_data.cls)
      irpd_pkg::CLS_START: begin
        cnt_a  = '0;
        code_a = '0;
      end
      irpd_pkg::CLS_ONE: begin
        code_a = code_r | (irpd_pkg::CODE_W'(1) << cnt_r);
        cnt_a  = cnt_r + CNT_W'(1);
      end
      irpd_pkg::CLS_ZERO: begin
        cnt_a  = cnt_r + CNT_W'(1);
      end
      default: begin
        cnt_a  = cnt_r;
      end
    endcase
  end

  assign done = (cnt_a == CNT_W'(FRAME_BITS));

  // Key decode on a completed frame.
  always_comb begin
    red_a   = red_r;
    green_a = green_r;
    blue_a  = blue_r;
    if (done) begin
      case (code_a)
        irpd_pkg::KEY_RED_UP:     red_a   = irpd_pkg::step_brighter(red_r, cfg.duty_step);
        irpd_pkg::KEY_RED_DOWN:   red_a   = irpd_pkg::step_darker(red_r, cfg.duty_step,
                                                                  cfg.full_scale);
        irpd_pkg::KEY_GREEN_UP:   green_a = irpd_pkg::step_brighter(green_r, cfg.duty_step);
        irpd_pkg::KEY_GREEN_DOWN: green_a = irpd_pkg::step_darker(green_r, cfg.duty_step,
                                                                  cfg.full_scale);
        irpd_pkg::KEY_BLUE_UP:    blue_a  = irpd_pkg::step_brighter(blue_r, cfg.duty_step);
        irpd_pkg::KEY_BLUE_DOWN:  blue_a  = irpd_pkg::step_darker(blue_r, cfg.duty_step,
                                                                  cfg.full_scale);
        irpd_pkg::KEY_RED_ON:     red_a   = '0;
        irpd_pkg::KEY_GREEN_ON:   green_a = '0;
        irpd_pkg::KEY_BLUE_ON:    blue_a  = '0;
        irpd_pkg::KEY_ALL_OFF: begin
          red_a   = cfg.full_scale;
          green_a = cfg.full_scale;
          blue_a  = cfg.full_scale;
        end
        irpd_pkg::KEY_ALL_ON: begin
          red_a   = '0;
          green_a = '0;
          blue_a  = '0;
        end
        default: begin
          red_a   = red_r;
        end
      endcase
    end
  end

  // State advances only when a pulse is taken.
  always_comb begin
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    if (q_pop) begin
      cnt_nxt   = done ? '0 : cnt_a;
      code_nxt  = code_a;
      red_nxt   = red_a;
      green_nxt = green_a;
      blue_nxt  = blue_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      code_r  <= '0;
      red_r   <= irpd_pkg::RST_LEVEL;
      green_r <= irpd_pkg::RST_LEVEL;
      blue_r  <= irpd_pkg::RST_LEVEL;
      vld_r   <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Result word fields; compare values come straight from the level registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cls_r  <= q_data.cls;
      ivl_r  <= q_data.interval;
      done_r <= done;
    end
  end

  assign out_valid       = vld_r;
  assign out_pulse_class = cls_r;
  assign out_interval    = ivl_r;
  assign out_frame_done  = done_r;
  assign out_frame_code  = code_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;

endmodule

`default_nettype wire

[rtl/ir_pulse_decoder_rgb_dimmer_unit.sv]
// IR pulse decoder with RGB dimmer, top level: configuration registers and the
// front end, queue and back end. Depends on irpd_pkg, irpd_if and the submodules.
//
// Usage:
//   in_ch carries one word per receiver edge: the 16-bit captured timer value.
//   out_ch returns one word per accepted edge: pulse class, interval, frame-done
//   flag, the code assembled so far and the red, green and blue compare values.
//   The APB port (byte address 4 * register index) holds the six window bounds,
//   the dimming step and the full-scale value; write it only while idle.
// Flow:
//   An accepted edge is written into the queue, then taken by the back end into
//   the output register, read by out_ch. One word per clock is sustained while
//   out_ch.ready is high; the back end's frame and level registers update once per word.
// Reset (rst_n low, synchronous): registers return to their defaults, the bit
//   count, code and previous timestamp clear and all channels go dark.
// Stall: a held output word stays in the output register; the two-entry queue
//   keeps taking edges until it fills, then in_ch.ready drops.
`default_nettype none

module ir_pulse_decoder_rgb_dimmer_unit #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  irpd_in_if.sink                             in_ch,
  irpd_out_if.source                          out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [irpd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [irpd_pkg::DATA_W-1:0]    pwdata,
  output logic [irpd_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  irpd_pkg::cfg_t     cfg_r, cfg_nxt;
  irpd_pkg::reg_idx_t reg_idx;
  logic               wr_en;
  logic [15:0]        rd_val;

  irpd_pkg::pulse_t   push_data, pop_data;
  logic               q_push, q_pop, q_full, q_empty;

  // Register file write decode.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = irpd_pkg::reg_idx_t'(paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        irpd_pkg::REG_START_MIN:  cfg_nxt.start_min  = pwdata[15:0];
        irpd_pkg::REG_START_MAX:  cfg_nxt.start_max  = pwdata[15:0];
        irpd_pkg::REG_ONE_MIN:    cfg_nxt.one_min    = pwdata[15:0];
        irpd_pkg::REG_ONE_MAX:    cfg_nxt.one_max    = pwdata[15:0];
        irpd_pkg::REG_ZERO_MIN:   cfg_nxt.zero_min   = pwdata[15:0];
        irpd_pkg::REG_ZERO_MAX:   cfg_nxt.zero_max   = pwdata[15:0];
        irpd_pkg::REG_DUTY_STEP:  cfg_nxt.duty_step  = pwdata[15:0];
        irpd_pkg::REG_FULL_SCALE: cfg_nxt.full_scale = pwdata[15:0];
        default:                  cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min  <= irpd_pkg::RST_START_MIN;
      cfg_r.start_max  <= irpd_pkg::RST_START_MAX;
      cfg_r.one_min    <= irpd_pkg::RST_ONE_MIN;
      cfg_r.one_max    <= irpd_pkg::RST_ONE_MAX;
      cfg_r.zero_min   <= irpd_pkg::RST_ZERO_MIN;
      cfg_r.zero_max   <= irpd_pkg::RST_ZERO_MAX;
      cfg_r.duty_step  <= irpd_pkg::RST_DUTY_STEP;
      cfg_r.full_scale <= irpd_pkg::RST_FULL_SCALE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      irpd_pkg::REG_START_MIN:  rd_val = cfg_r.start_min;
      irpd_pkg::REG_START_MAX:  rd_val = cfg_r.start_max;
      irpd_pkg::REG_ONE_MIN:    rd_val = cfg_r.one_min;
      irpd_pkg::REG_ONE_MAX:    rd_val = cfg_r.one_max;
      irpd_pkg::REG_ZERO_MIN:   rd_val = cfg_r.zero_min;
      irpd_pkg::REG_ZERO_MAX:   rd_val = cfg_r.zero_max;
      irpd_pkg::REG_DUTY_STEP:  rd_val = cfg_r.duty_step;
      irpd_pkg::REG_FULL_SCALE: rd_val = cfg_r.full_scale;
      default:                  rd_val = '0;
    endcase
  end

  assign prdata = {16'd0, rd_val};

  // Edge classification.
  irpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .edge_time (in_ch.edge_time),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  // Decoupling queue.
  irpd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_data),
    .pop   (q_pop),
    .rdata (pop_data),
    .full  (q_full),
    .empty (q_empty)
  );

  // Frame assembly, key handling and result register.
  irpd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (pop_data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_pulse_class (out_ch.pulse_class),
    .out_interval    (out_ch.interval),
    .out_frame_done  (out_ch.frame_done),
    .out_frame_code  (out_ch.frame_code),
    .out_red         (out_ch.red_compare),
    .out_green       (out_ch.green_compare),
    .out_blue        (out_ch.blue_compare)
  );

endmodule

`default_nettype wire

[rtl/irpd_checker.sv]
// Port-level checks for the IR pulse decoder with RGB dimmer, bound to the top.
// Depends on irpd_pkg for the pulse class codes.
`default_nettype none

module irpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  pulse_class,
  input wire logic        frame_done,
  input wire logic [31:0] frame_code
);

  // A word waiting on a stalled receiver is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A start pulse clears the code and never completes a frame.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pulse_class == irpd_pkg::CLS_START) |-> (frame_code == '0) && !frame_done)
    else $error("start pulse did not clear the frame");

  // Only a data bit can complete a frame.
  a_done_on_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |->
      (pulse_class == irpd_pkg::CLS_ONE) || (pulse_class == irpd_pkg::CLS_ZERO))
    else $error("frame completed without a data bit");

endmodule

bind ir_pulse_decoder_rgb_dimmer_unit irpd_checker u_irpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pulse_class (out_ch.pulse_class),
  .frame_done  (out_ch.frame_done),
  .frame_code  (out_ch.frame_code)
);

`default_nettype wire
